@@ src/dpp_pkg.sv @@
// Package for the depth pixel to point unit: frame sizes, register map, shared types.
`timescale 1ns / 1ps
`default_nettype none

package dpp_pkg;

  // Frame geometry
  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;
  localparam int unsigned COL_W        = 10;
  localparam int unsigned ROW_W        = 9;

  // Field and register widths
  localparam int unsigned DEPTH_W = 11;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CFG_W   = 34;
  localparam int unsigned IDX_W   = 3;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_INV_FOCAL_X      = 3'd0,
    REG_INV_FOCAL_Y      = 3'd1,
    REG_CENTER_X         = 3'd2,
    REG_CENTER_Y         = 3'd3,
    REG_DISPARITY_GAIN   = 3'd4,
    REG_DISPARITY_OFFSET = 3'd5
  } reg_idx_e;

  // Register file contents seen by the datapath
  typedef struct packed {
    logic        [31:0] inv_focal_x;
    logic        [31:0] inv_focal_y;
    logic        [15:0] center_x;
    logic        [15:0] center_y;
    logic signed [33:0] disparity_gain;
    logic signed [33:0] disparity_offset;
  } cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SETUP,
    ST_DIV,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic add_en;
    logic setup_en;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic w_pos;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ src/dpp_cfg_regs.sv @@
// Configuration register file of the depth pixel to point unit.
`timescale 1ns / 1ps
`default_nettype none

module dpp_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [dpp_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [dpp_pkg::CFG_W-1:0]  cfg_wdata_i,
  output dpp_pkg::cfg_t                   cfg_o
);

  dpp_pkg::cfg_t cfg_q;

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_focal_x      <= 32'd7228071;
      cfg_q.inv_focal_y      <= 32'd7266850;
      cfg_q.center_x         <= 16'd5432;
      cfg_q.center_y         <= 16'd3883;
      cfg_q.disparity_gain   <= -34'sd3297568;
      cfg_q.disparity_offset <= 34'sd3576579792;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dpp_pkg::REG_INV_FOCAL_X:      cfg_q.inv_focal_x      <= cfg_wdata_i[31:0];
        dpp_pkg::REG_INV_FOCAL_Y:      cfg_q.inv_focal_y      <= cfg_wdata_i[31:0];
        dpp_pkg::REG_CENTER_X:         cfg_q.center_x         <= cfg_wdata_i[15:0];
        dpp_pkg::REG_CENTER_Y:         cfg_q.center_y         <= cfg_wdata_i[15:0];
        dpp_pkg::REG_DISPARITY_GAIN:   cfg_q.disparity_gain   <= $signed(cfg_wdata_i);
        dpp_pkg::REG_DISPARITY_OFFSET: cfg_q.disparity_offset <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/dpp_ctrl.sv @@
// Controller state machine of the depth pixel to point unit.
`timescale 1ns / 1ps
`default_nettype none

module dpp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dpp_pkg::status_t status_i,
  output dpp_pkg::cmd_t         cmd_o
);

  dpp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dpp_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = dpp_pkg::ST_MUL;
      end
      dpp_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = dpp_pkg::ST_ADD;
      end
      dpp_pkg::ST_ADD: begin
        cmd_o.add_en = 1'b1;
        state_d      = dpp_pkg::ST_SETUP;
      end
      dpp_pkg::ST_SETUP: begin
        cmd_o.setup_en = 1'b1;
        // skip the divider when w is not positive
        state_d = status_i.w_pos ? dpp_pkg::ST_DIV : dpp_pkg::ST_FINISH;
      end
      dpp_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = dpp_pkg::ST_FINISH;
      end
      dpp_pkg::ST_FINISH: begin
        // hold the result until the output register is free
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = dpp_pkg::ST_IDLE;
        end
      end
      default: state_d = dpp_pkg::ST_IDLE;
    endcase
  end

  a_load_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded over a pending beat");

  a_div_only_positive_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> status_i.w_pos)
    else $error("divider stepped with non-positive w");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("input ready while an item is in flight");

endmodule

`default_nettype wire

@@ src/dpp_datapath.sv @@
// Datapath of the depth pixel to point unit: counters, products, dividers, output register.
`timescale 1ns / 1ps
`default_nettype none

module dpp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dpp_pkg::cfg_t                 cfg_i,
  input  wire dpp_pkg::cmd_t                 cmd_i,
  output dpp_pkg::status_t                   status_o,
  input  wire logic [dpp_pkg::DEPTH_W-1:0]   depth_raw_i,
  input  wire logic [dpp_pkg::COLOR_W-1:0]   red_in_i,
  input  wire logic [dpp_pkg::COLOR_W-1:0]   green_in_i,
  input  wire logic [dpp_pkg::COLOR_W-1:0]   blue_in_i,
  input  wire logic                          start_of_frame_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [dpp_pkg::COORD_W-1:0] point_x_o,
  output logic signed [dpp_pkg::COORD_W-1:0] point_y_o,
  output logic signed [dpp_pkg::COORD_W-1:0] point_z_o,
  output logic [dpp_pkg::COLOR_W-1:0]        red_out_o,
  output logic [dpp_pkg::COLOR_W-1:0]        green_out_o,
  output logic [dpp_pkg::COLOR_W-1:0]        blue_out_o,
  output logic                               point_valid_o,
  output logic                               last_of_frame_o
);

  localparam int unsigned LANES  = 3;
  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANE_Z = 2;
  localparam int unsigned W_W    = 46;   // a*d + b
  localparam int unsigned DEN_W  = 45;   // positive w
  localparam int unsigned DIF_W  = 18;   // pixel offset from center, Q.4
  localparam int unsigned ABS_W  = 17;
  localparam int unsigned NUM_W  = 48;   // |offset| * inv_focal
  localparam int unsigned QUO_W  = 31;   // quotient bits below saturation
  localparam int unsigned HI_W   = 27;   // dividend bits above the quotient
  localparam int unsigned CNT_W  = 5;
  localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(QUO_W - 1);
  localparam logic [HI_W-1:0]    Z_HI      = HI_W'(1) << 15;  // 2^46 >> 31
  localparam logic [31:0]        SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_MIN   = 32'h8000_0000;

  // Pixel counters and captured beat
  logic [dpp_pkg::COL_W-1:0]   col_q, col_eff_q, col_eff_d, col_nxt;
  logic [dpp_pkg::ROW_W-1:0]   row_q, row_eff_q, row_eff_d, row_nxt;
  logic                        last_q;
  logic [dpp_pkg::DEPTH_W-1:0] depth_q;
  logic [dpp_pkg::COLOR_W-1:0] red_q, green_q, blue_q;

  assign col_eff_d = start_of_frame_i ? '0 : col_q;
  assign row_eff_d = start_of_frame_i ? '0 : row_q;

  // Advance the raster position
  always_comb begin
    col_nxt = col_eff_d + 1'b1;
    row_nxt = row_eff_d;
    if (col_eff_d == dpp_pkg::COL_W'(dpp_pkg::FRAME_WIDTH - 1)) begin
      col_nxt = '0;
      row_nxt = (row_eff_d == dpp_pkg::ROW_W'(dpp_pkg::FRAME_HEIGHT - 1)) ?
                '0 : row_eff_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      col_q <= col_nxt;
      row_q <= row_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      depth_q   <= depth_raw_i;
      red_q     <= red_in_i;
      green_q   <= green_in_i;
      blue_q    <= blue_in_i;
      col_eff_q <= col_eff_d;
      row_eff_q <= row_eff_d;
      last_q    <= (col_eff_d == dpp_pkg::COL_W'(dpp_pkg::FRAME_WIDTH - 1)) &&
                   (row_eff_d == dpp_pkg::ROW_W'(dpp_pkg::FRAME_HEIGHT - 1));
    end
  end

  // Offsets from the principal point and their products
  logic signed [DIF_W-1:0] dx, dy, ndx, ndy;
  logic [ABS_W-1:0]        adx, ady;
  logic [NUM_W:0]          mx_full, my_full;
  logic signed [W_W-1:0]   prod_d, prod_q, w_q;
  logic [NUM_W-1:0]        mx_q, my_q;
  logic [LANES-1:0]        neg_q, zero_q;

  assign dx  = $signed({4'b0, col_eff_q, 4'b0}) - $signed({2'b0, cfg_i.center_x});
  assign dy  = $signed({2'b0, cfg_i.center_y}) - $signed({5'b0, row_eff_q, 4'b0});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[DIF_W-1] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
  assign ady = dy[DIF_W-1] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];
  assign mx_full = adx * cfg_i.inv_focal_x;
  assign my_full = ady * cfg_i.inv_focal_y;
  assign prod_d  = $signed(cfg_i.disparity_gain) * $signed({1'b0, depth_q});

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q         <= prod_d;
      mx_q           <= mx_full[NUM_W-1:0];
      my_q           <= my_full[NUM_W-1:0];
      neg_q[LANE_X]  <= dx[DIF_W-1];
      neg_q[LANE_Y]  <= dy[DIF_W-1];
      neg_q[LANE_Z]  <= 1'b1;
      zero_q[LANE_X] <= (adx == '0) || (cfg_i.inv_focal_x == '0);
      zero_q[LANE_Y] <= (ady == '0) || (cfg_i.inv_focal_y == '0);
      zero_q[LANE_Z] <= 1'b0;
    end
  end

  // Add stage: w = a*d + b
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      w_q <= prod_q + {{(W_W - dpp_pkg::CFG_W){cfg_i.disparity_offset[dpp_pkg::CFG_W-1]}},
                       cfg_i.disparity_offset};
    end
  end

  logic             w_pos;
  logic [DEN_W-1:0] den;
  assign w_pos = !w_q[W_W-1] && (w_q != '0);
  assign den   = w_q[DEN_W-1:0];

  // Divider lanes: restoring long division, one quotient bit per step
  logic [HI_W-1:0]  hi   [LANES];
  logic [QUO_W-1:0] lo   [LANES];
  logic [DEN_W-1:0] rem_q [LANES];
  logic [DEN_W-1:0] rem_d [LANES];
  logic [QUO_W-1:0] lo_q  [LANES];
  logic [QUO_W-1:0] quo_q [LANES];
  logic [LANES-1:0] qbit, ovf_d, ovf_q;
  logic [DEN_W:0]   trial [LANES];
  logic [DEN_W:0]   diff  [LANES];
  logic [CNT_W-1:0] cnt_q;

  assign hi[LANE_X] = mx_q[NUM_W-1:NUM_W-HI_W];
  assign hi[LANE_Y] = my_q[NUM_W-1:NUM_W-HI_W];
  assign hi[LANE_Z] = Z_HI;
  assign lo[LANE_X] = {mx_q[NUM_W-HI_W-1:0], 10'b0};
  assign lo[LANE_Y] = {my_q[NUM_W-HI_W-1:0], 10'b0};
  assign lo[LANE_Z] = '0;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ovf_d[i] = {{(DEN_W - HI_W){1'b0}}, hi[i]} >= den;
      trial[i] = {rem_q[i], lo_q[i][QUO_W-1]};
      diff[i]  = trial[i] - {1'b0, den};
      qbit[i]  = trial[i] >= {1'b0, den};
      rem_d[i] = qbit[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_en) begin
      cnt_q <= LAST_STEP;
      for (int i = 0; i < LANES; i++) begin
        ovf_q[i] <= ovf_d[i];
        rem_q[i] <= ovf_d[i] ? '0 : {{(DEN_W - HI_W){1'b0}}, hi[i]};
        lo_q[i]  <= lo[i];
        quo_q[i] <= '0;
      end
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
      for (int i = 0; i < LANES; i++) begin
        rem_q[i] <= rem_d[i];
        lo_q[i]  <= {lo_q[i][QUO_W-2:0], 1'b0};
        quo_q[i] <= {quo_q[i][QUO_W-2:0], qbit[i]};
      end
    end
  end

  // Sign, saturate or clamp one coordinate
  function automatic logic [31:0] lane_result(input logic wpos, input logic zero,
                                              input logic ovf, input logic neg,
                                              input logic [QUO_W-1:0] quo);
    logic [31:0] qx;
    logic [31:0] r;
    qx = {1'b0, quo};
    if (!wpos) begin
      r = zero ? 32'h0 : (neg ? SAT_MIN : SAT_MAX);
    end else if (ovf) begin
      r = neg ? SAT_MIN : SAT_MAX;
    end else begin
      r = neg ? (32'h0 - qx) : qx;
    end
    return r;
  endfunction

  // Output register
  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      point_x_o       <= lane_result(w_pos, zero_q[LANE_X], ovf_q[LANE_X], neg_q[LANE_X],
                                     quo_q[LANE_X]);
      point_y_o       <= lane_result(w_pos, zero_q[LANE_Y], ovf_q[LANE_Y], neg_q[LANE_Y],
                                     quo_q[LANE_Y]);
      point_z_o       <= lane_result(w_pos, zero_q[LANE_Z], ovf_q[LANE_Z], neg_q[LANE_Z],
                                     quo_q[LANE_Z]);
      red_out_o       <= red_q;
      green_out_o     <= green_q;
      blue_out_o      <= blue_q;
      point_valid_o   <= w_pos;
      last_of_frame_o <= last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.w_pos    = w_pos;
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_free = out_free;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q[LANE_X] < den) && (rem_q[LANE_Z] < den))
    else $error("divider remainder not below divisor");

  a_invalid_point_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !w_pos |=> !point_valid_o && (point_z_o == SAT_MIN))
    else $error("non-positive w did not saturate z");

  a_counters_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> (col_q < dpp_pkg::COL_W'(dpp_pkg::FRAME_WIDTH)) &&
                      (row_q < dpp_pkg::ROW_W'(dpp_pkg::FRAME_HEIGHT)))
    else $error("raster counters left the frame");

endmodule

`default_nettype wire

@@ src/depth_pixel_to_point_unit.sv @@
// Top level of the depth pixel to point unit.
`timescale 1ns / 1ps
`default_nettype none

// Turns one raw disparity sample plus RGB colour per pixel, in raster order, into a
// point in signed Q16.16: w = gain*d + offset, x = (col-cx)*ifx/w, y = (cy-row)*ify/w,
// z = -1/w, with the colour passed through and the frame's last pixel marked. One
// pixel is in flight at a time. A pixel with w > 0 goes from its input beat to its result
// load through capture, multiply, add, divider setup, 31 divider steps and load; the
// three quotients come out of a restoring divider that yields one bit per cycle in
// each of three lanes, and that loop sets the rate. A pixel with w <= 0 skips the
// divider. The output register lets the next pixel be taken while a result beat
// still waits. Registers are written through a plain write port (index, data,
// enable) and should be changed only while the unit is idle.
module depth_pixel_to_point_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dpp_pkg::IDX_W-1:0]     cfg_index_i,
  input  wire logic [dpp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dpp_pkg::DEPTH_W-1:0]   depth_raw_i,
  input  wire logic [dpp_pkg::COLOR_W-1:0]   red_in_i,
  input  wire logic [dpp_pkg::COLOR_W-1:0]   green_in_i,
  input  wire logic [dpp_pkg::COLOR_W-1:0]   blue_in_i,
  input  wire logic                          start_of_frame_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [dpp_pkg::COORD_W-1:0] point_x_o,
  output logic signed [dpp_pkg::COORD_W-1:0] point_y_o,
  output logic signed [dpp_pkg::COORD_W-1:0] point_z_o,
  output logic [dpp_pkg::COLOR_W-1:0]        red_out_o,
  output logic [dpp_pkg::COLOR_W-1:0]        green_out_o,
  output logic [dpp_pkg::COLOR_W-1:0]        blue_out_o,
  output logic                               point_valid_o,
  output logic                               last_of_frame_o
);

  dpp_pkg::cfg_t    cfg;
  dpp_pkg::cmd_t    cmd;
  dpp_pkg::status_t status;

  dpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .depth_raw_i      (depth_raw_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .start_of_frame_i (start_of_frame_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .point_x_o        (point_x_o),
    .point_y_o        (point_y_o),
    .point_z_o        (point_z_o),
    .red_out_o        (red_out_o),
    .green_out_o      (green_out_o),
    .blue_out_o       (blue_out_o),
    .point_valid_o    (point_valid_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule

`default_nettype wire
